// File: rtl/core/frustum_sphere_point_cull_unit_assert.svh
// Assertion helpers for the frustum cull unit. The macros expect clk and
// rst_n in scope at the point of use.
`ifndef FRUSTUM_SPHERE_POINT_CULL_UNIT_ASSERT_SVH
`define FRUSTUM_SPHERE_POINT_CULL_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fsc_pkg.sv
`timescale 1ns / 1ps

package fsc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int PLANE_REGS  = 6;
    localparam int PIDX_W      = 3;
    localparam int CFG_W       = 64;
    localparam int COORD_W     = 16;
    localparam int RADIUS_W    = 15;
    localparam int Q_FRAC      = 14;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int OFF_W       = COORD_W + 1;
    localparam int SUM_W       = 36;

    localparam logic [PIDX_W-1:0] INSIDE_CODE = PIDX_W'(6);

    typedef logic [PIDX_W-1:0] plane_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] d;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nx;
    } plane_t;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [RADIUS_W-1:0]       radius;
    } in_req_t;

    typedef struct packed {
        logic       inside_res;
        plane_idx_t first_failing_plane;
    } out_res_t;

    // Load strobes for the two arithmetic stages inside each plane unit.
    typedef struct packed {
        logic prod_load;
        logic sum_load;
    } stage_en_t;

endpackage

// File: rtl/core/fsc_plane_dist.sv
`timescale 1ns / 1ps

module fsc_plane_dist (
    input  logic                                   clk,
    input  fsc_pkg::plane_t                        plane,
    input  fsc_pkg::in_req_t                       req,
    input  fsc_pkg::stage_en_t                     en,
    output logic signed [fsc_pkg::SUM_W-1:0]       distance
);

    logic signed [fsc_pkg::PROD_W-1:0] prod_x_next;
    logic signed [fsc_pkg::PROD_W-1:0] prod_y_next;
    logic signed [fsc_pkg::PROD_W-1:0] prod_z_next;
    logic signed [fsc_pkg::OFF_W-1:0]  off_next;
    logic signed [fsc_pkg::OFF_W-1:0]  rad_ext;
    logic signed [fsc_pkg::PROD_W-1:0] prod_x_reg;
    logic signed [fsc_pkg::PROD_W-1:0] prod_y_reg;
    logic signed [fsc_pkg::PROD_W-1:0] prod_z_reg;
    logic signed [fsc_pkg::OFF_W-1:0]  off_reg;
    logic signed [fsc_pkg::SUM_W-1:0]  sum_next;
    logic signed [fsc_pkg::SUM_W-1:0]  sum_reg;

    // The radius only counts for spheres; it joins the plane offset so the
    // sum stage adds one shifted term for both.
    always_comb
    begin
        rad_ext     = req.kind ? signed'({2'b00, req.radius}) : '0;
        prod_x_next = plane.nx * req.pos_x;
        prod_y_next = plane.ny * req.pos_y;
        prod_z_next = plane.nz * req.pos_z;
        off_next    = fsc_pkg::OFF_W'(plane.d) + rad_ext;
    end

    always_ff @(posedge clk)
    begin
        if (en.prod_load)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            off_reg    <= off_next;
        end
    end

    always_comb
    begin
        sum_next = fsc_pkg::SUM_W'(prod_x_reg) + fsc_pkg::SUM_W'(prod_y_reg)
                 + fsc_pkg::SUM_W'(prod_z_reg)
                 + (fsc_pkg::SUM_W'(off_reg) <<< fsc_pkg::Q_FRAC);
    end

    always_ff @(posedge clk)
    begin
        if (en.sum_load)
        begin
            sum_reg <= sum_next;
        end
    end

    assign distance = sum_reg;

endmodule

// File: rtl/core/frustum_sphere_point_cull_unit.sv
// Channel   Handshake               Payload
// in        in_valid / in_ready     in_data   (fsc_pkg::in_req_t)
// out       out_valid / out_ready   out_data  (fsc_pkg::out_res_t)
// cfg       cfg_we                  cfg_index, cfg_data (plane registers 0..5)
//
// Four register stages: input, products, plane sums, result. One request
// enters per cycle unless out_ready stalls; results come out in order.
// Each stage moves when the one after it is empty or moving, so bubbles
// close up and a stall on out_ready holds every item in place.
// Reset clears the valid bits and all plane registers to zero.
`timescale 1ns / 1ps
`include "frustum_sphere_point_cull_unit_assert.svh"

module frustum_sphere_point_cull_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  fsc_pkg::in_req_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output fsc_pkg::out_res_t                out_data,
    input  logic                             cfg_we,
    input  logic [fsc_pkg::PIDX_W-1:0]       cfg_index,
    input  logic [fsc_pkg::CFG_W-1:0]        cfg_data
);

    fsc_pkg::plane_t   plane_reg [fsc_pkg::PLANE_REGS];
    fsc_pkg::in_req_t  req_reg;
    fsc_pkg::out_res_t res_reg;
    fsc_pkg::out_res_t res_next;
    fsc_pkg::stage_en_t en;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;
    logic adv_out;
    logic adv3;
    logic adv2;
    logic adv1;

    logic signed [fsc_pkg::SUM_W-1:0] plane_dist [fsc_pkg::PLANE_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fsc_pkg::PLANE_REGS; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < fsc_pkg::PLANE_REGS; i++)
            begin
                if (cfg_index == fsc_pkg::PIDX_W'(i))
                begin
                    plane_reg[i] <= fsc_pkg::plane_t'(cfg_data);
                end
            end
        end
    end

    always_comb
    begin
        adv_out = !out_valid_reg || out_ready;
        adv3    = !s3_valid_reg || adv_out;
        adv2    = !s2_valid_reg || adv3;
        adv1    = !s1_valid_reg || adv2;
        en.prod_load = adv2;
        en.sum_load  = adv3;
    end

    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            req_reg <= in_data;
        end
    end

    for (genvar p = 0; p < fsc_pkg::PLANE_COUNT; p++)
    begin : g_plane
        fsc_plane_dist u_dist (
            .clk      (clk),
            .plane    (plane_reg[p]),
            .req      (req_reg),
            .en       (en),
            .distance (plane_dist[p])
        );
    end

    // Lowest-numbered failing plane wins, so scan from the top down.
    always_comb
    begin
        res_next.first_failing_plane = fsc_pkg::INSIDE_CODE;
        for (int i = fsc_pkg::PLANE_COUNT - 1; i >= 0; i--)
        begin
            if (plane_dist[i] <= 0)
            begin
                res_next.first_failing_plane = fsc_pkg::PIDX_W'(i);
            end
        end
        res_next.inside_res = (res_next.first_failing_plane == fsc_pkg::INSIDE_CODE);
    end

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    `FSC_ASSERT_SAME(a_inside_matches_code, out_valid_reg,
        res_reg.inside_res == (res_reg.first_failing_plane == fsc_pkg::INSIDE_CODE),
        "inside flag disagrees with failing plane code")

    `FSC_ASSERT_SAME(a_code_in_range, out_valid_reg,
        res_reg.first_failing_plane <= fsc_pkg::INSIDE_CODE,
        "failing plane code out of range")

    `FSC_ASSERT_SAME(a_full_when_blocked, !in_ready,
        s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg && !out_ready,
        "input blocked while pipeline has room")

    `FSC_ASSERT_NEXT(a_sum_reaches_out, s3_valid_reg && adv_out,
        out_valid_reg,
        "request lost between sum stage and output")

endmodule

// File: dv/fsc_cull_checker.sv
`timescale 1ns / 1ps

module fsc_cull_checker
    import fsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  in_req_t           in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  out_res_t          out_data,
    input  logic              cfg_we,
    input  logic [PIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output int                fail_count,
    output int                verdicts_pending
);

    logic [CFG_W-1:0] plane_shadow [PLANE_REGS];
    out_res_t         verdict_q [$];
    int               mismatches;

    // Distances are kept at scale 2^14 in 64 bits, so the sum is exact.
    function automatic out_res_t cull_predict(input in_req_t req);
        out_res_t res;
        plane_t   pl;
        longint   one_q;
        longint   reach;
        longint   plane_sum;
        bit       failed;
        int       i;
        one_q = longint'(1) <<< Q_FRAC;
        reach = req.kind ? longint'(req.radius) * one_q : longint'(0);
        res.inside_res          = 1'b1;
        res.first_failing_plane = INSIDE_CODE;
        failed = 1'b0;
        for (i = 0; i < PLANE_COUNT && i < PLANE_REGS; i++)
        begin
            pl        = plane_t'(plane_shadow[i]);
            plane_sum = longint'(pl.nx) * longint'(req.pos_x)
                      + longint'(pl.ny) * longint'(req.pos_y)
                      + longint'(pl.nz) * longint'(req.pos_z)
                      + longint'(pl.d) * one_q + reach;
            if (!failed && plane_sum <= 0)
            begin
                failed                  = 1'b1;
                res.inside_res          = 1'b0;
                res.first_failing_plane = plane_idx_t'(i);
            end
        end
        return res;
    endfunction

    task automatic flag_result(input bit have_want, input out_res_t want, input out_res_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            if (have_want)
                $display("%0t: cull mismatch: expected inside=%0b plane=%0d, got inside=%0b plane=%0d",
                         $realtime, want.inside_res, want.first_failing_plane,
                         got.inside_res, got.first_failing_plane);
            else
                $display("%0t: cull result with no request waiting: inside=%0b plane=%0d",
                         $realtime, got.inside_res, got.first_failing_plane);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_res_t want;
        int       i;
        if (!rst_n)
        begin
            for (i = 0; i < PLANE_REGS; i++)
                plane_shadow[i] <= '0;
            verdict_q.delete();
            mismatches = 0;
            fail_count       <= 0;
            verdicts_pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                    flag_result(1'b0, '0, out_data);
                else
                begin
                    want = verdict_q.pop_front();
                    if (want.inside_res !== out_data.inside_res ||
                        want.first_failing_plane !== out_data.first_failing_plane)
                        flag_result(1'b1, want, out_data);
                end
            end
            // The shadow planes are updated by nonblocking assignment, so a
            // request accepted on this edge still sees the old planes.
            if (in_valid && in_ready)
                verdict_q.push_back(cull_predict(in_data));
            if (cfg_we && cfg_index < PLANE_REGS)
                plane_shadow[cfg_index] <= cfg_data;
            fail_count       <= mismatches;
            verdicts_pending <= verdict_q.size();
        end
    end

endmodule

// File: dv/tb_frustum_sphere_point_cull_unit.sv
`timescale 1ns / 1ps

module tb_frustum_sphere_point_cull_unit;
    import fsc_pkg::*;

    localparam int HALF_BOX  = 1000;
    localparam int WIDE_BOX  = 30000;
    localparam int ONE_NORM  = 1 << Q_FRAC;
    localparam int LATENCY   = 6;
    localparam int LONG_HOLD = 80;

    localparam logic [PIDX_W-1:0] REG_PAST_FAR  = PIDX_W'(6);
    localparam logic [PIDX_W-1:0] REG_LAST_CODE = PIDX_W'(7);

    typedef enum {
        PH_BOX,
        PH_WIDE_BOX,
        PH_FRUSTUM,
        PH_ONES,
        PH_ZERO,
        PH_POS_MAX,
        PH_NEG_MIN,
        PH_RAW
    } plane_setup_e;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_req_t           in_data;
    logic              out_valid;
    logic              out_ready;
    out_res_t          out_data;
    logic              cfg_we;
    logic [PIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    int                fail_count;
    int                verdicts_pending;
    bit                burst;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    frustum_sphere_point_cull_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fsc_cull_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .verdicts_pending (verdicts_pending)
    );

    function automatic logic [CFG_W-1:0] plane_word(input int nx, input int ny, input int nz,
                                                    input int d);
        plane_t pl;
        pl.nx = COORD_W'(nx);
        pl.ny = COORD_W'(ny);
        pl.nz = COORD_W'(nz);
        pl.d  = COORD_W'(d);
        return pl;
    endfunction

    function automatic in_req_t mk(input bit kind, input int x, input int y, input int z,
                                   input int rad);
        in_req_t req;
        req.kind   = kind;
        req.pos_x  = COORD_W'(x);
        req.pos_y  = COORD_W'(y);
        req.pos_z  = COORD_W'(z);
        req.radius = RADIUS_W'(rad);
        return req;
    endfunction

    // Short spans keep most requests near the planes; others cover the full range.
    function automatic in_req_t make_req(input int span);
        in_req_t req;
        bit      wide;
        wide = (span >= 32767) || ($urandom_range(0, 9) >= 7);
        req.kind = 1'($urandom_range(0, 1));
        if (wide)
        begin
            req.pos_x = COORD_W'($urandom);
            req.pos_y = COORD_W'($urandom);
            req.pos_z = COORD_W'($urandom);
        end
        else
        begin
            req.pos_x = COORD_W'(int'($urandom_range(0, 2 * span)) - span);
            req.pos_y = COORD_W'(int'($urandom_range(0, 2 * span)) - span);
            req.pos_z = COORD_W'(int'($urandom_range(0, 2 * span)) - span);
        end
        if ($urandom_range(0, 3) == 0)
            req.radius = RADIUS_W'($urandom);
        else
            req.radius = RADIUS_W'($urandom_range(0, span / 2));
        return req;
    endfunction

    task automatic cfg_write(input logic [PIDX_W-1:0] idx, input logic [CFG_W-1:0] word);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
    endtask

    task automatic set_planes(input plane_setup_e setup);
        logic [CFG_W-1:0] word;
        int               n [3];
        int               i;
        int               j;
        int               sgn;
        for (i = 0; i < PLANE_REGS; i++)
        begin
            // Left, bottom and near face the positive axis; the rest face back.
            sgn = (i == 0 || i == 3 || i == 4) ? 1 : -1;
            case (setup)
                PH_BOX, PH_WIDE_BOX:
                begin
                    n = '{0, 0, 0};
                    n[i / 2] = sgn * ONE_NORM;
                    word = plane_word(n[0], n[1], n[2],
                                      (setup == PH_BOX) ? HALF_BOX : WIDE_BOX);
                end
                PH_FRUSTUM:
                begin
                    for (j = 0; j < 3; j++)
                        n[j] = int'($urandom_range(0, 8192)) - 4096;
                    n[i / 2] = sgn * int'($urandom_range(8192, 32767));
                    word = plane_word(n[0], n[1], n[2], $urandom_range(0, 4000));
                end
                PH_ONES:    word = '1;
                PH_ZERO:    word = '0;
                PH_POS_MAX: word = plane_word(32767, 32767, 32767, 32767);
                PH_NEG_MIN:
                begin
                    if (i % 2 == 0)
                        word = plane_word(-32768, -32768, -32768, 32767);
                    else
                        word = plane_word(32767, 32767, 32767, -32768);
                end
                default:    word = {$urandom, $urandom};
            endcase
            cfg_write(PIDX_W'(i), word);
        end
        // Writes past the last plane must leave every plane untouched.
        if (setup == PH_BOX)
        begin
            cfg_write(REG_PAST_FAR, '1);
            cfg_write(REG_LAST_CODE, '1);
        end
        else if (setup == PH_RAW)
        begin
            cfg_write(REG_PAST_FAR, {$urandom, $urandom});
            cfg_write(REG_LAST_CODE, {$urandom, $urandom});
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_req(input in_req_t req);
        int gap;
        bit taken;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (verdicts_pending != 0);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Result side: random hold-offs, quiet stretches, and two long stalls
    // that back the pipeline up into the request side.
    initial
    begin
        int gap;
        int served;
        bit quiet;
        bit seen;
        out_ready = 1'b0;
        served    = 0;
        quiet     = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (served % 64 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            gap = quiet ? 0 : $urandom_range(0, 11);
            if (served == 250 || served == 550)
                gap = LONG_HOLD;
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                seen = out_valid;
                @(posedge clk);
            end
            while (!seen);
            served++;
        end
    end

    initial
    begin
        plane_setup_e sched [10];
        int           ph;
        int           k;
        int           span;
        sched = '{PH_FRUSTUM, PH_BOX, PH_RAW, PH_ONES, PH_FRUSTUM,
                  PH_POS_MAX, PH_NEG_MIN, PH_WIDE_BOX, PH_FRUSTUM, PH_ZERO};
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        burst     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Planes still at their reset value: only a sphere with a radius
        // gets past the zero plane.
        send_req(mk(1'b0, 0, 0, 0, 0));
        send_req(mk(1'b1, 0, 0, 0, 32767));
        send_req(mk(1'b1, 0, 0, 0, 0));
        send_req(mk(1'b0, -32768, 32767, -1, 32767));
        send_req(mk(1'b1, 32767, -32768, 0, 1));
        drain();

        set_planes(PH_BOX);
        send_req(mk(1'b0, 0, 0, 0, 0));
        send_req(mk(1'b1, 0, 0, 0, 0));
        send_req(mk(1'b0, -HALF_BOX, 0, 0, 0));
        send_req(mk(1'b0, -HALF_BOX + 1, 0, 0, 0));
        send_req(mk(1'b0, HALF_BOX, 0, 0, 0));
        send_req(mk(1'b0, 0, HALF_BOX, 0, 0));
        send_req(mk(1'b0, 0, -HALF_BOX, 0, 0));
        send_req(mk(1'b0, 0, 0, -HALF_BOX, 0));
        send_req(mk(1'b0, 0, 0, HALF_BOX, 0));
        send_req(mk(1'b1, -1500, 0, 0, 499));
        send_req(mk(1'b1, -1500, 0, 0, 500));
        send_req(mk(1'b1, -1500, 0, 0, 501));
        send_req(mk(1'b0, -1500, 0, 0, 32767));
        send_req(mk(1'b0, 32767, 32767, 32767, 0));
        send_req(mk(1'b0, -32768, -32768, -32768, 0));
        send_req(mk(1'b1, -32768, -32768, -32768, 32767));
        send_req(mk(1'b1, 32767, 32767, 32767, 32767));

        for (ph = 0; ph < 10; ph++)
        begin
            drain();
            set_planes(sched[ph]);
            case (sched[ph])
                PH_BOX:     span = HALF_BOX + 300;
                PH_FRUSTUM: span = 5000;
                default:    span = 32767;
            endcase
            for (k = 0; k < 80; k++)
            begin
                if (k % 16 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                send_req(make_req(span));
            end
        end
        drain();

        if (fail_count == 0 && verdicts_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
